[hdl/owik_pkg.sv]
package owik_pkg;

  // Default fixed-point and angle resolution
  localparam int FRAC_BITS_DEF  = 12;
  localparam int ANGLE_BITS_DEF = 16;

  // Q30 constants
  localparam int HALF30 = 1 << 29;
  localparam int COS30  = 929887697;
  localparam int SIN_A  = 1686629713;
  localparam int SIN_B  = 688904866;
  localparam int SIN_C  = 76016977;

  // Output saturation bounds
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [15:0] LINEAR_GAIN_RST      = 16'd12453;
  localparam logic [15:0] ANGULAR_GAIN_RST     = 16'd12106;
  localparam logic [15:0] BODY_RADIUS_RST      = 16'd614;
  localparam logic [19:0] INV_WHEEL_RADIUS_RST = 20'd136533;

  // Internal widths
  localparam int TRIG_PROD_W = 63;
  localparam int MIX_A_W     = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINEAR_GAIN      = 0,
    REG_ANGULAR_GAIN     = 1,
    REG_BODY_RADIUS      = 2,
    REG_INV_WHEEL_RADIUS = 3
  } owik_reg_e;

  typedef struct packed {
    logic [15:0] linear_gain;
    logic [15:0] angular_gain;
    logic [15:0] body_radius;
    logic [19:0] inv_wheel_radius;
  } owik_cfg_t;

  typedef struct packed {
    logic               func;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] turn_rate;
    logic        [15:0] heading;
  } owik_in_t;

  typedef struct packed {
    logic signed [23:0] wheel_a_speed;
    logic signed [23:0] wheel_b_speed;
    logic signed [23:0] wheel_c_speed;
  } owik_out_t;

  typedef struct packed {
    logic               func;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] turn_rate;
  } owik_cmd_t;

  typedef struct packed {
    logic signed [TRIG_PROD_W-1:0] sin_prod;
    logic signed [TRIG_PROD_W-1:0] cos_prod;
    owik_cmd_t                     cmd;
  } owik_trig_t;

  typedef struct packed {
    logic signed [MIX_A_W-1:0] a0;
    logic signed [MIX_A_W-1:0] a1;
    logic signed [15:0]        turn_rate;
  } owik_frame_t;

endpackage

[hdl/owik_trig.sv]
module owik_trig #(
  parameter int ANGLE_BITS = owik_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  owik_pkg::owik_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output owik_pkg::owik_trig_t out_data_o
);

  localparam int          NSTG      = 5;
  localparam int          PH_SHIFT  = 32 - ANGLE_BITS;
  localparam logic [31:0] PH_MASK   = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic [31:0] QUARTER   = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] THREE_Q   = 32'hC000_0000;

  // Fold phase into [-quarter, +quarter] turn
  function automatic logic signed [31:0] fold(input logic [31:0] ph);
    logic [31:0] q;
    if (ph >= QUARTER && ph < THREE_Q) begin
      q = HALF_TURN - ph;
    end else begin
      q = ph;
    end
    return signed'(q);
  endfunction

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  logic [31:0]        ph [2];
  logic signed [31:0] z_d [2];
  logic [60:0]        zz_d [2];
  logic [30:0]        z2_d [2];
  logic [56:0]        mc_d [2];
  logic [59:0]        mb_d [2];
  logic signed [62:0] mp_d [2];

  logic signed [31:0] s1_z_q [2];
  logic signed [31:0] s2_z_q [2];
  logic [60:0]        s2_zz_q [2];
  logic signed [31:0] s3_z_q [2];
  logic [30:0]        s3_z2_q [2];
  logic [56:0]        s3_mc_q [2];
  logic signed [31:0] s4_z_q [2];
  logic [59:0]        s4_mb_q [2];
  logic signed [62:0] s5_mp_q [2];

  owik_pkg::owik_cmd_t cmd_q [NSTG];

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_comb begin
    logic signed [63:0] sq;
    logic [61:0]        zz_r;
    logic [57:0]        mc_r;
    logic [29:0]        t;
    logic [60:0]        mb_r;
    logic [30:0]        poly;
    ph[0] = (32'(in_data_i.heading) & PH_MASK) << PH_SHIFT;
    ph[1] = ph[0] + QUARTER;
    for (int l = 0; l < 2; l++) begin
      z_d[l]  = fold(ph[l]);
      sq      = 64'(s1_z_q[l]) * 64'(s1_z_q[l]);
      zz_d[l] = sq[60:0];
      zz_r    = {1'b0, s2_zz_q[l]} + 62'(owik_pkg::HALF30);
      z2_d[l] = zz_r[60:30];
      mc_d[l] = 57'(z2_d[l]) * 57'(owik_pkg::SIN_C);
      mc_r    = {1'b0, s3_mc_q[l]} + 58'(owik_pkg::HALF30);
      t       = 30'(owik_pkg::SIN_B) - 30'(mc_r[57:30]);
      mb_d[l] = 60'(s3_z2_q[l]) * 60'(t);
      mb_r    = {1'b0, s4_mb_q[l]} + 61'(owik_pkg::HALF30);
      poly    = 31'(owik_pkg::SIN_A) - 31'(mb_r[60:30]);
      mp_d[l] = 63'(s4_z_q[l]) * 63'($signed({1'b0, poly}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_z_q[0]         <= z_d[0];
      s1_z_q[1]         <= z_d[1];
      cmd_q[0].func      <= in_data_i.func;
      cmd_q[0].vel_x     <= in_data_i.vel_x;
      cmd_q[0].vel_y     <= in_data_i.vel_y;
      cmd_q[0].turn_rate <= in_data_i.turn_rate;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) cmd_q[k] <= cmd_q[k-1];
    end
    for (int l = 0; l < 2; l++) begin
      if (en[1]) begin
        s2_z_q[l]  <= s1_z_q[l];
        s2_zz_q[l] <= zz_d[l];
      end
      if (en[2]) begin
        s3_z_q[l]  <= s2_z_q[l];
        s3_z2_q[l] <= z2_d[l];
        s3_mc_q[l] <= mc_d[l];
      end
      if (en[3]) begin
        s4_z_q[l]  <= s3_z_q[l];
        s4_mb_q[l] <= mb_d[l];
      end
      if (en[4]) s5_mp_q[l] <= mp_d[l];
    end
  end

  assign out_valid_o         = v_q[NSTG-1];
  assign out_data_o.sin_prod = s5_mp_q[0];
  assign out_data_o.cos_prod = s5_mp_q[1];
  assign out_data_o.cmd      = cmd_q[NSTG-1];

endmodule

[hdl/owik_frame.sv]
module owik_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  owik_pkg::owik_trig_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output owik_pkg::owik_frame_t out_data_o
);

  localparam int NSTG = 4;
  localparam int RX_W = 18;
  localparam int A_W  = owik_pkg::MIX_A_W;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  logic signed [31:0] sn;
  logic signed [31:0] cs;
  logic signed [47:0] cvx_d, svy_d, cvy_d, svx_d;
  logic signed [RX_W-1:0] rx_d, ry_d;
  logic signed [48:0] prx_d, pry_d;
  logic signed [A_W-1:0] a0_d, a1_d;

  logic               s1_func_q;
  logic signed [15:0] s1_vx_q, s1_vy_q;
  logic signed [47:0] s1_cvx_q, s1_svy_q, s1_cvy_q, s1_svx_q;
  logic signed [RX_W-1:0] s2_rx_q, s2_ry_q;
  logic signed [RX_W-1:0] s3_rx_q, s3_ry_q;
  logic signed [48:0] s3_prx_q, s3_pry_q;
  logic signed [A_W-1:0] s4_a0_q, s4_a1_q;
  logic signed [15:0] turn_q [NSTG];

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_comb begin
    logic signed [63:0] rs;
    logic signed [63:0] rc;
    logic signed [48:0] sx;
    logic signed [48:0] sy;
    logic signed [49:0] sa;
    logic signed [49:0] sb;
    // round sine and cosine back to Q30
    rs    = 64'(in_data_i.sin_prod) + 64'(owik_pkg::HALF30);
    rc    = 64'(in_data_i.cos_prod) + 64'(owik_pkg::HALF30);
    sn    = 32'(rs >>> 30);
    cs    = 32'(rc >>> 30);
    cvx_d = 48'(cs) * 48'(in_data_i.cmd.vel_x);
    svy_d = 48'(sn) * 48'(in_data_i.cmd.vel_y);
    cvy_d = 48'(cs) * 48'(in_data_i.cmd.vel_y);
    svx_d = 48'(sn) * 48'(in_data_i.cmd.vel_x);
    // robot-frame commands bypass the heading rotation
    sx    = 49'(s1_cvx_q) + 49'(s1_svy_q) + 49'(owik_pkg::HALF30);
    sy    = 49'(s1_cvy_q) - 49'(s1_svx_q) + 49'(owik_pkg::HALF30);
    rx_d  = s1_func_q ? RX_W'(s1_vx_q) : RX_W'(sx >>> 30);
    ry_d  = s1_func_q ? RX_W'(s1_vy_q) : RX_W'(sy >>> 30);
    prx_d = 49'(owik_pkg::COS30) * 49'(s2_rx_q);
    pry_d = 49'(owik_pkg::COS30) * 49'(s2_ry_q);
    sa    = (50'(s3_ry_q) <<< 29) - 50'(s3_prx_q) + 50'(owik_pkg::HALF30);
    sb    = -50'(s3_pry_q) - (50'(s3_rx_q) <<< 29) + 50'(owik_pkg::HALF30);
    a0_d  = A_W'(sa >>> 30);
    a1_d  = A_W'(sb >>> 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_func_q <= in_data_i.cmd.func;
      s1_vx_q   <= in_data_i.cmd.vel_x;
      s1_vy_q   <= in_data_i.cmd.vel_y;
      s1_cvx_q  <= cvx_d;
      s1_svy_q  <= svy_d;
      s1_cvy_q  <= cvy_d;
      s1_svx_q  <= svx_d;
      turn_q[0] <= in_data_i.cmd.turn_rate;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) turn_q[k] <= turn_q[k-1];
    end
    if (en[1]) begin
      s2_rx_q <= rx_d;
      s2_ry_q <= ry_d;
    end
    if (en[2]) begin
      s3_rx_q  <= s2_rx_q;
      s3_ry_q  <= s2_ry_q;
      s3_prx_q <= prx_d;
      s3_pry_q <= pry_d;
    end
    if (en[3]) begin
      s4_a0_q <= a0_d;
      s4_a1_q <= a1_d;
    end
  end

  assign out_valid_o          = v_q[NSTG-1];
  assign out_data_o.a0        = s4_a0_q;
  assign out_data_o.a1        = s4_a1_q;
  assign out_data_o.turn_rate = turn_q[NSTG-1];

endmodule

[hdl/owik_wheel.sv]
module owik_wheel #(
  parameter int FRAC_BITS = owik_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  owik_pkg::owik_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  owik_pkg::owik_frame_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output owik_pkg::owik_out_t   out_data_o
);

  localparam int NSTG   = 5;
  localparam int P0_W   = 36;
  localparam int P2_W   = 33;
  localparam int I_W    = P0_W - FRAC_BITS;
  localparam int I2_W   = P2_W - FRAC_BITS;
  localparam int PA_W   = 31 + I_W;
  localparam int PBR_W  = 17 + I2_W;
  localparam int BR_W   = 49 - 2 * FRAC_BITS;
  localparam int MIX_W  = I_W + 1;
  localparam int S_W    = ((MIX_W > BR_W) ? MIX_W : BR_W) + 1;
  localparam int Q_W    = S_W + 21;
  localparam int HALF_F = 1 << (FRAC_BITS - 1);

  localparam logic signed [Q_W:0] SAT_HI = (Q_W + 1)'(owik_pkg::OUT_MAX);
  localparam logic signed [Q_W:0] SAT_LO = (Q_W + 1)'(owik_pkg::OUT_MIN);

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  logic signed [P0_W-1:0]  p0_d, p1_d;
  logic signed [P2_W-1:0]  p2_d;
  logic signed [I_W-1:0]   i1_d;
  logic signed [PA_W-1:0]  pa_d;
  logic signed [PBR_W-1:0] pbr_d;
  logic signed [S_W-1:0]   s_d [3];
  logic signed [Q_W-1:0]   q_d [3];
  logic signed [23:0]      w_d [3];

  logic signed [P0_W-1:0]  s1_p0_q, s1_p1_q;
  logic signed [P2_W-1:0]  s1_p2_q;
  logic signed [PA_W-1:0]  s2_pa_q;
  logic signed [I_W-1:0]   s2_i1_q;
  logic signed [PBR_W-1:0] s2_pbr_q;
  logic signed [S_W-1:0]   s3_s_q [3];
  logic signed [Q_W-1:0]   s4_q_q [3];
  logic signed [23:0]      s5_w_q [3];

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_comb begin
    logic signed [P0_W:0]    r0, r1;
    logic signed [P2_W:0]    r2;
    logic signed [I_W-1:0]   i0;
    logic signed [I2_W-1:0]  i2;
    logic signed [PA_W+1:0]  ma, mc;
    logic signed [PBR_W:0]   rb;
    logic signed [BR_W-1:0]  br;
    logic signed [MIX_W-1:0] mix_a, mix_c;
    logic signed [Q_W:0]     rq;
    // correction gains
    p0_d  = P0_W'(in_data_i.a0) * P0_W'($signed({1'b0, cfg_i.linear_gain}));
    p1_d  = P0_W'(in_data_i.a1) * P0_W'($signed({1'b0, cfg_i.linear_gain}));
    p2_d  = P2_W'(in_data_i.turn_rate) * P2_W'($signed({1'b0, cfg_i.angular_gain}));
    // round gains, start the omni matrix
    r0    = (P0_W + 1)'(s1_p0_q) + (P0_W + 1)'(HALF_F);
    r1    = (P0_W + 1)'(s1_p1_q) + (P0_W + 1)'(HALF_F);
    r2    = (P2_W + 1)'(s1_p2_q) + (P2_W + 1)'(HALF_F);
    i0    = I_W'(r0 >>> FRAC_BITS);
    i1_d  = I_W'(r1 >>> FRAC_BITS);
    i2    = I2_W'(r2 >>> FRAC_BITS);
    pa_d  = PA_W'(owik_pkg::COS30) * PA_W'(i0);
    pbr_d = PBR_W'($signed({1'b0, cfg_i.body_radius})) * PBR_W'(i2);
    // mix and add the rotation term
    ma    = (PA_W + 2)'(s2_pa_q) - ((PA_W + 2)'(s2_i1_q) <<< 29)
          + (PA_W + 2)'(owik_pkg::HALF30);
    mc    = -(PA_W + 2)'(s2_pa_q) - ((PA_W + 2)'(s2_i1_q) <<< 29)
          + (PA_W + 2)'(owik_pkg::HALF30);
    mix_a = MIX_W'(ma >>> 30);
    mix_c = MIX_W'(mc >>> 30);
    rb    = (PBR_W + 1)'(s2_pbr_q) + (PBR_W + 1)'(HALF_F);
    br    = BR_W'(rb >>> FRAC_BITS);
    s_d[0] = S_W'(mix_a) + S_W'(br);
    s_d[1] = S_W'(s2_i1_q) + S_W'(br);
    s_d[2] = S_W'(mix_c) + S_W'(br);
    for (int l = 0; l < 3; l++) begin
      q_d[l] = Q_W'(s3_s_q[l]) * Q_W'($signed({1'b0, cfg_i.inv_wheel_radius}));
      rq     = ((Q_W + 1)'(s4_q_q[l]) + (Q_W + 1)'(HALF_F)) >>> FRAC_BITS;
      if (rq > SAT_HI) begin
        w_d[l] = 24'(SAT_HI);
      end else if (rq < SAT_LO) begin
        w_d[l] = 24'(SAT_LO);
      end else begin
        w_d[l] = 24'(rq);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_p0_q <= p0_d;
      s1_p1_q <= p1_d;
      s1_p2_q <= p2_d;
    end
    if (en[1]) begin
      s2_pa_q  <= pa_d;
      s2_i1_q  <= i1_d;
      s2_pbr_q <= pbr_d;
    end
    for (int l = 0; l < 3; l++) begin
      if (en[2]) s3_s_q[l] <= s_d[l];
      if (en[3]) s4_q_q[l] <= q_d[l];
      if (en[4]) s5_w_q[l] <= w_d[l];
    end
  end

  assign out_valid_o              = v_q[NSTG-1];
  assign out_data_o.wheel_a_speed = s5_w_q[0];
  assign out_data_o.wheel_b_speed = s5_w_q[1];
  assign out_data_o.wheel_c_speed = s5_w_q[2];

endmodule

[hdl/omni_wheel_inverse_kinematics.sv]
// Three-wheel omni-drive inverse kinematics. Each input beat carries a
// velocity command (x, y, turn rate, Q4.12) and a heading; with func low the
// command is world-frame and is rotated into the robot frame by the sine and
// cosine of the heading, with func high it is used as is. The output beat
// holds the three wheel speeds, Q12.12, saturated to 24 bits. One beat is
// taken every clock cycle unless the full pipe is stalled. Each beat crosses
// five stages of sine/cosine polynomial (phase fold, then one multiply each),
// four of frame rotation and 30/60-degree mixing, five of gains, omni matrix,
// wheel radius scaling and saturation. Stages hold their data under output
// stall and empty stages fill, so input is stalled only once the whole pipe
// is full. Write the configuration registers only while the pipe is empty.

module omni_wheel_inverse_kinematics #(
  parameter int FRAC_BITS  = owik_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = owik_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [owik_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [owik_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // command channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  owik_pkg::owik_in_t                  in_data_i,
  // wheel speed channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output owik_pkg::owik_out_t                 out_data_o
);

  owik_pkg::owik_cfg_t cfg_q;

  // trig -> frame
  logic                 trig_valid;
  logic                 trig_stall;
  owik_pkg::owik_trig_t trig_data;

  // frame -> wheel
  logic                  frame_valid;
  logic                  frame_stall;
  owik_pkg::owik_frame_t frame_data;

  // Register writes: drop unknown indexes and bits above the register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.linear_gain      <= owik_pkg::LINEAR_GAIN_RST;
      cfg_q.angular_gain     <= owik_pkg::ANGULAR_GAIN_RST;
      cfg_q.body_radius      <= owik_pkg::BODY_RADIUS_RST;
      cfg_q.inv_wheel_radius <= owik_pkg::INV_WHEEL_RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (owik_pkg::owik_reg_e'(cfg_idx_i))
        owik_pkg::REG_LINEAR_GAIN: begin
          cfg_q.linear_gain <= cfg_data_i[15:0];
        end
        owik_pkg::REG_ANGULAR_GAIN: begin
          cfg_q.angular_gain <= cfg_data_i[15:0];
        end
        owik_pkg::REG_BODY_RADIUS: begin
          cfg_q.body_radius <= cfg_data_i[15:0];
        end
        owik_pkg::REG_INV_WHEEL_RADIUS: begin
          cfg_q.inv_wheel_radius <= cfg_data_i[19:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Heading sine and cosine, command carried alongside
  owik_trig #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_trig (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (trig_valid),
    .out_stall_i (trig_stall),
    .out_data_o  (trig_data)
  );

  // Rotate into robot frame, apply the fixed mixing rotation
  owik_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (trig_valid),
    .in_stall_o  (trig_stall),
    .in_data_i   (trig_data),
    .out_valid_o (frame_valid),
    .out_stall_i (frame_stall),
    .out_data_o  (frame_data)
  );

  // Gains, omni matrix, wheel radius and saturation
  owik_wheel #(
    .FRAC_BITS (FRAC_BITS)
  ) u_wheel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (frame_valid),
    .in_stall_o  (frame_stall),
    .in_data_i   (frame_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/sv/owik_tb_pkg.sv]
`timescale 1ns / 100ps

package owik_tb_pkg;
  import owik_pkg::*;

  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int ANGLE = ANGLE_BITS_DEF;

  // Q30 mixing constants and sine polynomial coefficients
  localparam longint HALF_Q30  = 64'sd536870912;
  localparam longint COS30_Q30 = 64'sd929887697;
  localparam longint POLY_K1   = 64'sd1686629713;
  localparam longint POLY_K3   = 64'sd688904866;
  localparam longint POLY_K5   = 64'sd76016977;

  localparam longint WHEEL_MAX = 64'sd8388607;
  localparam longint WHEEL_MIN = -64'sd8388608;

  // Round half up, then drop n fraction bits.
  function automatic longint round_drop(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Q30 sine of a phase where 2^32 is one full turn.
  function automatic longint quarter_wave_sine(bit [31:0] ph);
    bit [31:0] q;
    longint z, z2, poly;
    q = ph;
    if (q >= 32'h4000_0000 && q < 32'hC000_0000) begin
      q = 32'h8000_0000 - q;
    end
    z    = longint'($signed(q));
    z2   = round_drop(z * z, 30);
    poly = POLY_K1 - round_drop(z2 * (POLY_K3 - round_drop(z2 * POLY_K5, 30)), 30);
    return round_drop(z * poly, 30);
  endfunction

  class wheel_scoreboard;
    bit [15:0] lin_gain;
    bit [15:0] ang_gain;
    bit [15:0] body_rad;
    bit [19:0] inv_wheel_rad;
    owik_out_t expected_wheels[$];
    int errors;
    int cmds_seen;
    int world_cmds;
    int beats_checked;

    function new();
      lin_gain      = 16'd12453;
      ang_gain      = 16'd12106;
      body_rad      = 16'd614;
      inv_wheel_rad = 20'd136533;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LINEAR_GAIN:      lin_gain      = data[15:0];
        REG_ANGULAR_GAIN:     ang_gain      = data[15:0];
        REG_BODY_RADIUS:      body_rad      = data[15:0];
        REG_INV_WHEEL_RADIUS: inv_wheel_rad = data[19:0];
        default: ;
      endcase
    endfunction

    function logic [23:0] scale_wheel(longint s);
      longint v;
      v = round_drop(s * longint'(inv_wheel_rad), FRAC);
      if (v > WHEEL_MAX) v = WHEEL_MAX;
      if (v < WHEEL_MIN) v = WHEEL_MIN;
      return v[23:0];
    endfunction

    function owik_out_t predict_wheels(owik_in_t cmd);
      longint vx, vy, w, rx, ry, sn, cs, a0, a1, i0, i1, i2, br;
      bit [31:0] ph;
      owik_out_t wheels;
      vx = longint'($signed(cmd.vel_x));
      vy = longint'($signed(cmd.vel_y));
      w  = longint'($signed(cmd.turn_rate));
      if (cmd.func == 1'b0) begin
        ph = 32'(cmd.heading & ((1 << ANGLE) - 1)) << (32 - ANGLE);
        sn = quarter_wave_sine(ph);
        cs = quarter_wave_sine(ph + 32'h4000_0000);
        rx = round_drop(cs * vx + sn * vy, 30);
        ry = round_drop(cs * vy - sn * vx, 30);
      end else begin
        rx = vx;
        ry = vy;
      end
      a0 = round_drop(HALF_Q30 * ry - COS30_Q30 * rx, 30);
      a1 = round_drop(-COS30_Q30 * ry - HALF_Q30 * rx, 30);
      i0 = round_drop(a0 * longint'(lin_gain), FRAC);
      i1 = round_drop(a1 * longint'(lin_gain), FRAC);
      i2 = round_drop(w * longint'(ang_gain), FRAC);
      br = round_drop(longint'(body_rad) * i2, FRAC);
      wheels.wheel_a_speed = scale_wheel(round_drop(COS30_Q30 * i0 - HALF_Q30 * i1, 30) + br);
      wheels.wheel_b_speed = scale_wheel(i1 + br);
      wheels.wheel_c_speed = scale_wheel(round_drop(-COS30_Q30 * i0 - HALF_Q30 * i1, 30) + br);
      return wheels;
    endfunction

    function void note_cmd(owik_in_t cmd);
      cmds_seen++;
      if (cmd.func == 1'b0) world_cmds++;
      expected_wheels.push_back(predict_wheels(cmd));
    endfunction

    function int pending();
      return expected_wheels.size();
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: MISMATCH %s", $time, what);
      errors++;
    endtask

    task compare_speed(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("beat %0d %s: got %0d, want %0d", beats_checked, name,
                                  $signed(got), $signed(want)));
      end
    endtask

    task check_wheels(owik_out_t got);
      owik_out_t want;
      if (expected_wheels.size() == 0) begin
        report_mismatch("wheel beat with no command outstanding");
        return;
      end
      want = expected_wheels.pop_front();
      compare_speed("wheel_a_speed", got.wheel_a_speed, want.wheel_a_speed);
      compare_speed("wheel_b_speed", got.wheel_b_speed, want.wheel_b_speed);
      compare_speed("wheel_c_speed", got.wheel_c_speed, want.wheel_c_speed);
      beats_checked++;
    endtask
  endclass

endpackage

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import owik_pkg::*;
  import owik_tb_pkg::*;

  // This limit leaves a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;

  logic                  clk      = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  owik_in_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  owik_out_t             out_data;

  // Set to suppress both sender gaps and receiver stalls.
  bit no_idle = 1'b0;
  int settings_loaded = 0;
  int cycle_count = 0;

  wheel_scoreboard sb;

  omni_wheel_inverse_kinematics u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the wheel-speed channel on about a fifth of the cycles.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 21);
  end

  // Compare every wheel-speed beat taken at this edge; values read here are
  // the ones that were stable before the edge.
  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_wheels(out_data);
    end
  end

  function automatic owik_in_t make_cmd(logic func, logic [15:0] vx, logic [15:0] vy,
                                        logic [15:0] w, logic [15:0] hd);
    owik_in_t cmd;
    cmd.func      = func;
    cmd.vel_x     = vx;
    cmd.vel_y     = vy;
    cmd.turn_rate = w;
    cmd.heading   = hd;
    return cmd;
  endfunction

  // Mix full-scale corners, slow speeds and uniform values.
  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_heading();
    if ($urandom_range(0, 4) == 0) begin
      // Land on or next to a quadrant boundary.
      return {2'($urandom_range(0, 3)), 14'h0} + 16'($urandom_range(0, 2)) - 16'd1;
    end
    return 16'($urandom);
  endfunction

  // Drive one command beat and hold it until the block takes it.
  task automatic send_cmd(input owik_in_t cmd);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_cmd(cmd);
  endtask

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) begin
      send_cmd(make_cmd(1'($urandom), pick_speed(), pick_speed(), pick_speed(),
                        pick_heading()));
    end
  endtask

  // Drop valid and hold off until every predicted wheel beat has come back.
  task automatic wait_for_wheels();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Write all four registers, the three 16-bit ones with junk in the unused
  // upper bits, plus one write to an unmapped index that must change nothing.
  // Call only while the pipe is empty.
  task automatic load_settings(input logic [15:0] lin, input logic [15:0] ang,
                               input logic [15:0] rad, input logic [19:0] inv);
    put_reg(REG_LINEAR_GAIN, {4'($urandom), lin});
    put_reg(REG_ANGULAR_GAIN, {4'($urandom), ang});
    put_reg(REG_BODY_RADIUS, {4'($urandom), rad});
    put_reg(REG_INV_WHEEL_RADIUS, inv);
    put_reg(CFG_IDX_W'(REG_INV_WHEEL_RADIUS + 1 + $urandom_range(0, 3)), 20'($urandom));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic run_directed();
    // Zero command, both frames.
    send_cmd(make_cmd(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(make_cmd(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h8000));
    // Full-scale robot-frame corners; heading is ignored in this mode.
    send_cmd(make_cmd(1'b1, 16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF));
    send_cmd(make_cmd(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h0000));
    send_cmd(make_cmd(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1234));
    send_cmd(make_cmd(1'b1, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000));
    send_cmd(make_cmd(1'b1, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000));
    send_cmd(make_cmd(1'b1, 16'h0000, 16'h0000, 16'h8000, 16'h0000));
    // One metre per second along x (and once along y), swept through the quadrant boundaries.
    send_cmd(make_cmd(1'b0, 16'h1000, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(make_cmd(1'b0, 16'h1000, 16'h0000, 16'h0000, 16'h2000));
    send_cmd(make_cmd(1'b0, 16'h1000, 16'h0000, 16'h0000, 16'h4000));
    send_cmd(make_cmd(1'b0, 16'h1000, 16'h0000, 16'h0000, 16'h8000));
    send_cmd(make_cmd(1'b0, 16'h1000, 16'h0000, 16'h0000, 16'hC000));
    send_cmd(make_cmd(1'b0, 16'h1000, 16'h0000, 16'h0000, 16'hFFFF));
    send_cmd(make_cmd(1'b0, 16'h0000, 16'h1000, 16'h0000, 16'h3FFF));
    // World-frame extremes at odd headings.
    send_cmd(make_cmd(1'b0, 16'h8000, 16'h7FFF, 16'h0000, 16'h6000));
    send_cmd(make_cmd(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hE000));
    send_cmd(make_cmd(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'hA000));
    send_cmd(make_cmd(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001));
    send_cmd(make_cmd(1'b0, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h5555));
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;

    // Reset values: directed corners first, then random traffic.
    run_directed();
    run_random(100);
    wait_for_wheels();

    // Every register at its maximum: drives the wheel speeds into saturation.
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
    run_random(50);
    wait_for_wheels();

    // Every register at zero: all wheel speeds must read zero.
    load_settings(16'h0000, 16'h0000, 16'h0000, 20'h00000);
    run_random(30);
    wait_for_wheels();

    // Moderate random gains; run a stretch with no gaps or stalls, then hold
    // the sender until the pipe has drained before resuming.
    load_settings(16'($urandom_range(0, 16383)), 16'($urandom_range(0, 16383)),
                  16'($urandom_range(0, 4095)), 20'($urandom_range(0, 262143)));
    run_random(10);
    no_idle = 1'b1;
    run_random(50);
    no_idle = 1'b0;
    wait_for_wheels();
    run_random(40);
    wait_for_wheels();

    // Full-range random gains.
    load_settings(16'($urandom), 16'($urandom), 16'($urandom), 20'($urandom));
    run_random(60);
    wait_for_wheels();

    // Back to the reset values by explicit writes.
    load_settings(LINEAR_GAIN_RST, ANGULAR_GAIN_RST, BODY_RADIUS_RST, INV_WHEEL_RADIUS_RST);
    run_random(60);
    wait_for_wheels();

    // Let the pipe settle so any stray beat would still be caught.
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("wheel beats still outstanding at end of run");

    $display("Sent %0d velocity commands (%0d world-frame, %0d robot-frame) over %0d register loads",
             sb.cmds_seen, sb.world_cmds, sb.cmds_seen - sb.world_cmds, settings_loaded);
    $display("Compared %0d wheel-speed beats, %0d mismatches", sb.beats_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/owik_pkg.sv
hdl/owik_trig.sv
hdl/owik_frame.sv
hdl/owik_wheel.sv
hdl/omni_wheel_inverse_kinematics.sv
tb/sv/owik_tb_pkg.sv
tb/sv/tb_top.sv
